FILE: rtl/ihm_pkg.sv
`timescale 1ns / 1ps

package ihm_pkg;

  // Histogram geometry and the widths of the fields.
  localparam int unsigned MaxPixels = 65536;
  localparam int unsigned BinCount  = 256;
  localparam int unsigned KindW     = 2;
  localparam int unsigned IdxW      = $clog2(BinCount);
  localparam int unsigned CntW      = 17;
  localparam int unsigned SumW      = 24;
  localparam int unsigned ProbFrac  = 16;
  localparam int unsigned MeanFrac  = 8;
  localparam int unsigned ProbW     = 17;
  localparam int unsigned MeanW     = 16;

  // Dividend width of the shared divider: the wider of count << 16 and sum << 8.
  localparam int unsigned DivW    = (CntW + ProbFrac > SumW + MeanFrac) ?
                                    (CntW + ProbFrac) : (SumW + MeanFrac);
  localparam int unsigned DivCntW = $clog2(DivW);

  // Request kinds.
  localparam logic [KindW-1:0] KIND_ADD   = 2'd0;
  localparam logic [KindW-1:0] KIND_BIN   = 2'd1;
  localparam logic [KindW-1:0] KIND_MEAN  = 2'd2;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the request and read the bin memory
    logic clear;      // clear all bins, the total, the sum and the overflow flag
    logic add_wr;     // write back an incremented bin or flag the overflow
    logic div_start;  // start the divider on the latched request
    logic out_load;   // load the result into the output register
  } ihm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;   // the divider finishes its last step this cycle
    logic out_free;   // the output register can take a result this cycle
  } ihm_sts_t;

endpackage

FILE: rtl/ihm_div.sv
`timescale 1ns / 1ps

module ihm_div import ihm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    dq_q, dq_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    dsr_q, dsr_d;
  logic [CntW:0]      trial;
  logic [CntW+1:0]    diff;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, dq_q[DivW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW - 1);
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[CntW+1]) begin
        rem_d = trial[CntW-1:0];
        dq_d  = {dq_q[DivW-2:0], 1'b0};
      end else begin
        rem_d = diff[CntW-1:0];
        dq_d  = {dq_q[DivW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = dq_q;

endmodule

FILE: rtl/ihm_dp.sv
`timescale 1ns / 1ps

module ihm_dp import ihm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ihm_cmd_t         cmd_i,
  output ihm_sts_t         sts_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdxW-1:0]  pixel_value_i,
  input  logic [IdxW-1:0]  bin_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CntW-1:0]  bin_count_o,
  output logic [ProbW-1:0] bin_probability_o,
  output logic [MeanW-1:0] mean_level_o,
  output logic [CntW-1:0]  pixel_total_o,
  output logic             empty_image_o,
  output logic             overflowed_o
);

  // Bin memory with one valid bit per bin; an invalid bin reads as zero.
  logic [CntW-1:0]     mem_q [BinCount];
  logic [BinCount-1:0] bin_vld_q;
  logic [CntW-1:0]     rd_data_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_addr;

  // Latched request and running totals.
  logic [KindW-1:0]    kind_q;
  logic [IdxW-1:0]     pix_q;
  logic [CntW-1:0]     total_q;
  logic [SumW-1:0]     sum_q;
  logic                ovf_q;

  // Divider interface.
  logic [DivW-1:0]     dividend;
  logic [DivW-1:0]     quotient;
  logic                div_done;

  // Output register.
  logic                out_vld_q;
  logic [CntW-1:0]     out_cnt_q;
  logic [ProbW-1:0]    out_prob_q;
  logic [MeanW-1:0]    out_mean_q;
  logic [CntW-1:0]     out_total_q;
  logic                out_empty_q;
  logic                out_ovf_q;

  logic [CntW-1:0]     count;
  logic                full;
  logic                empty;

  assign count = rd_vld_q ? rd_data_q : '0;
  assign full  = (total_q >= CntW'(MaxPixels));
  assign empty = (total_q == '0);

  // The address comes from the pixel for an add and from the bin index otherwise.
  assign rd_addr = (kind_i == KIND_ADD) ? pixel_value_i : bin_index_i;

  // Latch the request fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      pix_q  <= pixel_value_i;
    end
  end

  // Memory read on acceptance, write back of an incremented bin.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= bin_vld_q[rd_addr];
    end
    if (cmd_i.add_wr && !full) begin
      mem_q[pix_q] <= count + CntW'(1);
    end
  end

  // Valid bits, totals and the overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      total_q   <= '0;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.clear) begin
      bin_vld_q <= '0;
      total_q   <= '0;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.add_wr) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        bin_vld_q[pix_q] <= 1'b1;
        total_q          <= total_q + CntW'(1);
        sum_q            <= sum_q + SumW'(pix_q);
      end
    end
  end

  // Probability divides count << 16, the mean divides sum << 8, both by the total.
  assign dividend = (kind_q == KIND_BIN) ? DivW'({count, ProbFrac'(0)})
                                         : DivW'({sum_q, MeanFrac'(0)});

  ihm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output payload; quotients read as zero for an empty image.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cnt_q   <= (kind_q == KIND_BIN) ? count : '0;
      out_prob_q  <= ((kind_q == KIND_BIN) && !empty) ? quotient[ProbW-1:0] : '0;
      out_mean_q  <= ((kind_q == KIND_MEAN) && !empty) ? quotient[MeanW-1:0] : '0;
      out_total_q <= total_q;
      out_empty_q <= empty;
      out_ovf_q   <= ovf_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o       = out_vld_q;
  assign bin_count_o       = out_cnt_q;
  assign bin_probability_o = out_prob_q;
  assign mean_level_o      = out_mean_q;
  assign pixel_total_o     = out_total_q;
  assign empty_image_o     = out_empty_q;
  assign overflowed_o      = out_ovf_q;

endmodule

FILE: rtl/ihm_ctrl.sv
`timescale 1ns / 1ps

module ihm_ctrl import ihm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] kind_i,
  output logic             in_ready_o,
  input  ihm_sts_t         sts_i,
  output ihm_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.accept     = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_ADD:   state_d = S_ADD;
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end
            default:    state_d = S_START;
          endcase
        end
      end
      S_ADD: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/image_histogram_with_mean.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   kind_i, pixel_value_i, bin_index_i
// out       output     out_valid_o / out_ready_i bin_count_o, bin_probability_o,
//                                                mean_level_o, pixel_total_o,
//                                                empty_image_o, overflowed_o
//
// An add-pixel request reads the bin on acceptance, then writes it back.
// A clear request drops the per-bin valid bits at once.
// A bin or mean request runs acceptance, divider start, 33 steps of
// the bit-serial divider that retires one quotient bit each, and the output load.
// Reset clears all bins, the total, the sum and the flag with no clearing pass.
// A waiting result does not hold off adds or clears; the next read result
// is loaded once the output register is taken.

module image_histogram_with_mean import ihm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdxW-1:0]  pixel_value_i,
  input  logic [IdxW-1:0]  bin_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CntW-1:0]  bin_count_o,
  output logic [ProbW-1:0] bin_probability_o,
  output logic [MeanW-1:0] mean_level_o,
  output logic [CntW-1:0]  pixel_total_o,
  output logic             empty_image_o,
  output logic             overflowed_o
);

  ihm_cmd_t cmd;
  ihm_sts_t sts;

  // Sequencer.
  ihm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Bin memory, totals, divider and output register.
  ihm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .pixel_value_i     (pixel_value_i),
    .bin_index_i       (bin_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bin_count_o       (bin_count_o),
    .bin_probability_o (bin_probability_o),
    .mean_level_o      (mean_level_o),
    .pixel_total_o     (pixel_total_o),
    .empty_image_o     (empty_image_o),
    .overflowed_o      (overflowed_o)
  );

endmodule

FILE: rtl/ihm_checker.sv
`timescale 1ns / 1ps

module ihm_checker import ihm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CntW-1:0]  bin_count_o,
  input logic [ProbW-1:0] bin_probability_o,
  input logic [MeanW-1:0] mean_level_o,
  input logic [CntW-1:0]  pixel_total_o,
  input logic             empty_image_o
);

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // The empty flag agrees with the total.
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_image_o == (pixel_total_o == '0)))
    else $error("empty flag disagrees with the pixel total");

  // An empty image gives zero probability and zero mean.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_image_o |-> (bin_probability_o == '0) && (mean_level_o == '0))
    else $error("nonzero quotient for an empty image");

  // A bin never holds more than the total.
  a_bin_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bin_count_o <= pixel_total_o))
    else $error("bin count exceeds the pixel total");

  // A result is either a bin read or a mean read, never both.
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_level_o == '0) || ((bin_count_o == '0) &&
                    (bin_probability_o == '0)))
    else $error("bin and mean fields both set");

endmodule

bind image_histogram_with_mean ihm_checker u_ihm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .bin_count_o       (bin_count_o),
  .bin_probability_o (bin_probability_o),
  .mean_level_o      (mean_level_o),
  .pixel_total_o     (pixel_total_o),
  .empty_image_o     (empty_image_o)
);

FILE: test/hist_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the histogram block, keeps its own histogram,
// predicts the reply of every read request and compares each reply with it.
module hist_checker import ihm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdxW-1:0]  pixel_value_i,
  input  logic [IdxW-1:0]  bin_index_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CntW-1:0]  bin_count_i,
  input  logic [ProbW-1:0] bin_probability_i,
  input  logic [MeanW-1:0] mean_level_i,
  input  logic [CntW-1:0]  pixel_total_i,
  input  logic             empty_image_i,
  input  logic             overflowed_i,
  output int unsigned      err_count_o,
  output int unsigned      replies_due_o
);

  // One reply of a bin or mean request.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [ProbW-1:0] prob;
    logic [MeanW-1:0] mean;
    logic [CntW-1:0]  total;
    logic             empty;
    logic             ovf;
  } hist_reply_t;

  localparam int unsigned MaxErrLines = 200;

  logic [CntW-1:0] bin_tally [BinCount];
  logic [CntW-1:0] tally_total;
  logic [SumW-1:0] level_sum;
  logic            pixels_dropped;
  hist_reply_t     replies_due [$];
  int unsigned     err_count = 0;

  assign err_count_o = err_count;

  // Prints one line per error, up to a cap, and counts every one.
  task automatic report_error(input string msg);
    if (err_count < MaxErrLines) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void clear_histogram();
    foreach (bin_tally[i]) begin
      bin_tally[i] = '0;
    end
    tally_total    = '0;
    level_sum      = '0;
    pixels_dropped = 1'b0;
  endfunction

  // Applies one accepted request to the histogram and queues its reply, if any.
  function automatic void apply_request(input logic [KindW-1:0] kind,
                                        input logic [IdxW-1:0] pix,
                                        input logic [IdxW-1:0] idx);
    hist_reply_t              reply;
    logic [CntW+ProbFrac-1:0] prob_num;
    logic [SumW+MeanFrac-1:0] mean_num;
    reply = '0;
    case (kind)
      KIND_ADD: begin
        // A full histogram drops the pixel and only raises the flag.
        if (tally_total >= MaxPixels) begin
          pixels_dropped = 1'b1;
        end else begin
          bin_tally[pix] = bin_tally[pix] + 1'b1;
          tally_total    = tally_total + 1'b1;
          level_sum      = level_sum + pix;
        end
      end
      KIND_CLEAR: begin
        clear_histogram();
      end
      KIND_BIN, KIND_MEAN: begin
        // Quotients stay zero on an empty histogram.
        if (kind == KIND_BIN) begin
          reply.count = bin_tally[idx];
          if (tally_total != '0) begin
            prob_num   = {reply.count, {ProbFrac{1'b0}}};
            reply.prob = ProbW'(prob_num / tally_total);
          end
        end else if (tally_total != '0) begin
          mean_num   = {level_sum, {MeanFrac{1'b0}}};
          reply.mean = MeanW'(mean_num / tally_total);
        end
        reply.total = tally_total;
        reply.empty = (tally_total == '0);
        reply.ovf   = pixels_dropped;
        replies_due.push_back(reply);
      end
      default: begin
      end
    endcase
  endfunction

  // Both channels are sampled on the rising edge, before any update of that edge.
  always @(posedge clk_i) begin
    hist_reply_t want;
    if (!rst_ni) begin
      clear_histogram();
      replies_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          report_error("reply arrived with no request waiting");
        end else begin
          want = replies_due.pop_front();
          check_field("bin_count", bin_count_i, want.count);
          check_field("bin_probability", bin_probability_i, want.prob);
          check_field("mean_level", mean_level_i, want.mean);
          check_field("pixel_total", pixel_total_i, want.total);
          check_field("empty_image", empty_image_i, want.empty);
          check_field("overflowed", overflowed_i, want.ovf);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_request(kind_i, pixel_value_i, bin_index_i);
      end
    end
    replies_due_o <= replies_due.size();
  end

endmodule

FILE: test/tb_image_histogram_with_mean.sv
`timescale 1ns / 1ps

// Drives requests into the histogram block with random gaps and stalls the
// reply channel at random; the checker beside the block judges every reply.
module tb_image_histogram_with_mean;
  import ihm_pkg::*;

  localparam int unsigned RandomItems = 1700;
  localparam int unsigned DrainEvery  = 300;
  localparam int unsigned TailCycles  = 64;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned MaxGap      = 13;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [KindW-1:0] kind_i = KIND_ADD;
  logic [IdxW-1:0]  pixel_value_i = '0;
  logic [IdxW-1:0]  bin_index_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b1;
  logic [CntW-1:0]  bin_count_o;
  logic [ProbW-1:0] bin_probability_o;
  logic [MeanW-1:0] mean_level_o;
  logic [CntW-1:0]  pixel_total_o;
  logic             empty_image_o;
  logic             overflowed_o;

  int unsigned err_count;
  int unsigned replies_due;
  int unsigned cycle_cnt = 0;
  int unsigned ready_hold = 0;
  int unsigned stall_draw;
  bit          quiet = 1'b0;

  always #1 clk_i = ~clk_i;

  image_histogram_with_mean u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .pixel_value_i    (pixel_value_i),
    .bin_index_i      (bin_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bin_count_o      (bin_count_o),
    .bin_probability_o(bin_probability_o),
    .mean_level_o     (mean_level_o),
    .pixel_total_o    (pixel_total_o),
    .empty_image_o    (empty_image_o),
    .overflowed_o     (overflowed_o)
  );

  hist_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .pixel_value_i    (pixel_value_i),
    .bin_index_i      (bin_index_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bin_count_i      (bin_count_o),
    .bin_probability_i(bin_probability_o),
    .mean_level_i     (mean_level_o),
    .pixel_total_i    (pixel_total_o),
    .empty_image_i    (empty_image_o),
    .overflowed_i     (overflowed_o),
    .err_count_o      (err_count),
    .replies_due_o    (replies_due)
  );

  // After each taken reply the receiver may stall for a random number of cycles.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      stall_draw = quiet ? 0 : $urandom_range(0, MaxGap);
      ready_hold <= stall_draw;
      out_ready_i <= (stall_draw == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready_i <= (ready_hold == 1);
    end
  end

  // Ends a run that hangs.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sends one request after a random gap; valid stays high when the gap is zero.
  task automatic send_req(input logic [KindW-1:0] kind, input logic [IdxW-1:0] pix,
                          input logic [IdxW-1:0] idx);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    pixel_value_i <= pix;
    bin_index_i   <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Unused fields carry random bits, since the block must ignore them.
  task automatic add_pixel(input logic [IdxW-1:0] pix);
    send_req(KIND_ADD, pix, IdxW'($urandom));
  endtask

  task automatic read_bin(input logic [IdxW-1:0] idx);
    send_req(KIND_BIN, IdxW'($urandom), idx);
  endtask

  task automatic read_mean();
    send_req(KIND_MEAN, IdxW'($urandom), IdxW'($urandom));
  endtask

  task automatic clear_hist();
    send_req(KIND_CLEAR, IdxW'($urandom), IdxW'($urandom));
  endtask

  // Holds off new requests until every reply due has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned     sent;
    int unsigned     next_drain;
    int unsigned     img_len;
    int unsigned     roll;
    logic [IdxW-1:0] palette [4];

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads of an empty histogram, a single zero pixel, then a few bins.
    read_bin(8'd0);
    read_mean();
    add_pixel(8'd0);
    read_mean();
    add_pixel(8'd255);
    add_pixel(8'd255);
    add_pixel(8'd128);
    read_bin(8'd255);
    read_bin(8'd0);
    read_bin(8'd128);
    read_bin(8'd7);
    read_mean();
    clear_hist();
    read_bin(8'd255);
    read_mean();
    wait_drained();

    // Random images: mostly pixels, half of them from a small palette, with reads mixed in.
    sent       = 0;
    next_drain = DrainEvery;
    while (sent < RandomItems) begin
      quiet   = ($urandom_range(0, 3) == 0);
      img_len = $urandom_range(1, 60);
      foreach (palette[i]) begin
        palette[i] = IdxW'($urandom);
      end
      repeat (img_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          add_pixel($urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : IdxW'($urandom));
        end else if (roll < 85) begin
          read_bin($urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : IdxW'($urandom));
        end else if (roll < 95) begin
          read_mean();
        end else begin
          send_req(KindW'($urandom), IdxW'($urandom), IdxW'($urandom));
        end
        sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
        clear_hist();
        sent++;
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += DrainEvery;
      end
    end

    // Let every reply arrive, then watch for stray ones.
    quiet = 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
